[rtl/ctp_pkg.sv]
// Shared constants, types and saturation helper for the cubic trajectory point block.
`timescale 1ns / 1ps
package ctp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TQ        = 30;
  localparam int DW        = 32;
  localparam int DVS_W     = 31;
  localparam int NUM_W     = 64 - (TQ - FRAC_BITS);
  localparam int POS_W     = 96 - TQ - FRAC_BITS;
  localparam int VP_W      = 36;
  localparam int W_W       = 36;
  localparam int WM_W      = 31;
  localparam int SAT_W     = 64;

  localparam logic signed [SAT_W-1:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [SAT_W-1:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

  typedef enum logic [1:0] {
    KIND_OK,
    KIND_BAD,
    KIND_EARLY,
    KIND_LATE
  } kind_t;

  typedef struct packed {
    kind_t           kind;
    logic            eq;
    logic [DW-1:0]   p0;
    logic [DW-1:0]   v0;
    logic [DW-1:0]   p1;
    logic [DW-1:0]   v1;
  } side_a_t;

  typedef struct packed {
    logic [DW-1:0]          pos;
    logic signed [VP_W-1:0] velp;
    logic                   fneg;
    logic                   ok;
    logic                   status;
  } side_b_t;

  localparam int SIDE_W  = $bits(side_a_t);
  localparam int SIDEB_W = $bits(side_b_t);

  typedef struct packed {
    logic [DVS_W-1:0]  rem;
    logic [NUM_W-1:0]  num;
    logic [DVS_W-1:0]  dvs;
    logic [SIDE_W-1:0] side;
  } div_word_t;

  function automatic logic [DW-1:0] sat32(input logic signed [SAT_W-1:0] x);
    logic [DW-1:0] r;
    if (x > SAT_HI) begin
      r = SAT_HI[DW-1:0];
    end else if (x < SAT_LO) begin
      r = SAT_LO[DW-1:0];
    end else begin
      r = x[DW-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/ctp_div_cell.sv]
// One restoring division step: shifts one dividend bit into the remainder per cycle while en is high.
`timescale 1ns / 1ps
module ctp_div_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  ctp_pkg::div_word_t word_i,
  output logic              vld_o,
  output ctp_pkg::div_word_t word_o
);
  import ctp_pkg::*;

  logic             vld_r;
  div_word_t        word_r;
  div_word_t        word_nxt;
  logic [DVS_W:0]   sh;
  logic [DVS_W:0]   diff;
  logic             ge;

  always_comb begin
    sh            = {word_i.rem, word_i.num[NUM_W-1]};
    diff          = sh - {1'b0, word_i.dvs};
    ge            = (sh >= {1'b0, word_i.dvs});
    word_nxt      = word_i;
    word_nxt.rem  = ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
    word_nxt.num  = {word_i.num[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign word_o = word_r;

endmodule

[rtl/ctp_poly.sv]
// Seven-stage pipeline that forms the cubic weights, the products and the position.
`timescale 1ns / 1ps
module ctp_poly (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic [ctp_pkg::DVS_W-1:0] s_i,
  input  ctp_pkg::side_a_t     side_i,
  input  logic [ctp_pkg::DVS_W-1:0] dvs_i,
  output logic                 vld_o,
  output ctp_pkg::div_word_t   word_o
);
  import ctp_pkg::*;

  function automatic logic [WM_W-1:0] wmag(input logic signed [W_W-1:0] x);
    logic [W_W-1:0] m;
    m = x[W_W-1] ? W_W'(-x) : W_W'(x);
    return m[WM_W-1:0];
  endfunction

  // Stage 1: s squared.
  logic             q1_vld_r;
  logic [DVS_W-1:0] q1_s_r, q1_s2_r, q1_dvs_r;
  side_a_t          q1_side_r;
  logic [61:0]      sq;

  // Stage 2: s cubed.
  logic             q2_vld_r;
  logic [DVS_W-1:0] q2_s_r, q2_s2_r, q2_s3_r, q2_dvs_r;
  side_a_t          q2_side_r;
  logic [61:0]      cu;

  // Stage 3: weights and magnitudes.
  logic signed [W_W-1:0] ws, ws2, ws3, wp, wa, wb, wv0, wv1, wd;
  logic signed [DW:0]    dp;
  logic             q3_vld_r;
  logic [WM_W-1:0]  q3_wpm_r, q3_wam_r, q3_wbm_r, q3_wv0m_r, q3_wv1m_r, q3_wdm_r;
  logic             q3_wpn_r, q3_wan_r, q3_wbn_r, q3_wv0n_r, q3_wv1n_r;
  logic [DW:0]      q3_dpm_r;
  logic             q3_dpn_r;
  logic [DW-1:0]    q3_v0m_r, q3_v1m_r;
  logic             q3_v0n_r, q3_v1n_r;
  logic [DVS_W-1:0] q3_dvs_r;
  side_a_t          q3_side_r;
  logic [DW:0]      dpm_nxt;
  logic [DW-1:0]    v0m_nxt, v1m_nxt;

  // Stage 4: first products.
  logic             q4_vld_r;
  logic [63:0]      q4_pa_r, q4_pf_r;
  logic [62:0]      q4_pd_r, q4_pe_r, q4_mv0_r, q4_mv1_r;
  logic [WM_W-1:0]  q4_wam_r, q4_wbm_r;
  logic             q4_aneg_r, q4_bneg_r, q4_cneg_r, q4_dneg_r, q4_eneg_r, q4_fneg_r;
  logic [DVS_W-1:0] q4_dvs_r;
  side_a_t          q4_side_r;

  // Stage 5: scaled narrow terms and partial products of the wide terms.
  logic             q5_vld_r;
  logic [33:0]      q5_a_r;
  logic [32:0]      q5_d_r, q5_e_r;
  logic [NUM_W-1:0] q5_f_r;
  logic [62:0]      q5_blo_r, q5_clo_r;
  logic [61:0]      q5_bhi_r, q5_chi_r;
  logic             q5_aneg_r, q5_bneg_r, q5_cneg_r, q5_dneg_r, q5_eneg_r, q5_fneg_r;
  logic [DVS_W-1:0] q5_dvs_r;
  side_a_t          q5_side_r;

  // Stage 6: signed narrow terms, velocity partial sum, wide term magnitudes.
  logic [94:0]      bfull, cfull;
  logic signed [VP_W-1:0] as_nxt, ds_nxt, es_nxt;
  logic             q6_vld_r;
  logic signed [VP_W-1:0] q6_as_r, q6_velp_r;
  logic [POS_W-1:0] q6_bm_r, q6_cm_r;
  logic             q6_bneg_r, q6_cneg_r, q6_fneg_r;
  logic [NUM_W-1:0] q6_f_r;
  logic [DVS_W-1:0] q6_dvs_r;
  side_a_t          q6_side_r;

  // Stage 7: position sum, outcome selection and divider word.
  logic signed [SAT_W-1:0] bs, cs, psum;
  side_b_t          sb;
  div_word_t        q7_word_nxt;
  logic             q7_vld_r;
  div_word_t        q7_word_r;

  always_comb begin
    sq = s_i * s_i;
    cu = q1_s2_r * q1_s_r;
  end

  always_comb begin
    ws   = W_W'(q2_s_r);
    ws2  = W_W'(q2_s2_r);
    ws3  = W_W'(q2_s3_r);
    wp   = 3 * ws2 - 2 * ws3;
    wa   = ws - 2 * ws2 + ws3;
    wb   = ws3 - ws2;
    wv0  = (W_W'(1) <<< TQ) - 4 * ws + 3 * ws2;
    wv1  = 3 * ws2 - 2 * ws;
    wd   = 6 * (ws - ws2);
    dp   = $signed({q2_side_r.p1[DW-1], q2_side_r.p1})
         - $signed({q2_side_r.p0[DW-1], q2_side_r.p0});
    dpm_nxt = dp[DW] ? (DW+1)'(-dp) : (DW+1)'(dp);
    v0m_nxt = q2_side_r.v0[DW-1] ? (-q2_side_r.v0) : q2_side_r.v0;
    v1m_nxt = q2_side_r.v1[DW-1] ? (-q2_side_r.v1) : q2_side_r.v1;
  end

  always_comb begin
    bfull  = {q5_bhi_r, 32'b0} + 95'(q5_blo_r);
    cfull  = {q5_chi_r, 32'b0} + 95'(q5_clo_r);
    as_nxt = q5_aneg_r ? -$signed(VP_W'(q5_a_r)) : $signed(VP_W'(q5_a_r));
    ds_nxt = q5_dneg_r ? -$signed(VP_W'(q5_d_r)) : $signed(VP_W'(q5_d_r));
    es_nxt = q5_eneg_r ? -$signed(VP_W'(q5_e_r)) : $signed(VP_W'(q5_e_r));
  end

  always_comb begin
    bs   = q6_bneg_r ? -$signed(SAT_W'(q6_bm_r)) : $signed(SAT_W'(q6_bm_r));
    cs   = q6_cneg_r ? -$signed(SAT_W'(q6_cm_r)) : $signed(SAT_W'(q6_cm_r));
    psum = SAT_W'($signed(q6_side_r.p0)) + SAT_W'(q6_as_r) + bs + cs;
    sb.velp   = q6_velp_r;
    sb.fneg   = q6_fneg_r;
    sb.ok     = (q6_side_r.kind == KIND_OK);
    sb.status = (q6_side_r.kind == KIND_BAD);
    unique case (q6_side_r.kind)
      KIND_OK:    sb.pos = sat32(psum);
      KIND_BAD:   sb.pos = '0;
      KIND_EARLY: sb.pos = q6_side_r.p0;
      KIND_LATE:  sb.pos = q6_side_r.p1;
      default:    sb.pos = '0;
    endcase
    q7_word_nxt.rem  = '0;
    q7_word_nxt.num  = q6_f_r;
    q7_word_nxt.dvs  = q6_dvs_r;
    q7_word_nxt.side = SIDE_W'(sb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_vld_r <= 1'b0;
      q2_vld_r <= 1'b0;
      q3_vld_r <= 1'b0;
      q4_vld_r <= 1'b0;
      q5_vld_r <= 1'b0;
      q6_vld_r <= 1'b0;
      q7_vld_r <= 1'b0;
    end else if (en) begin
      q1_vld_r <= vld_i;
      q2_vld_r <= q1_vld_r;
      q3_vld_r <= q2_vld_r;
      q4_vld_r <= q3_vld_r;
      q5_vld_r <= q4_vld_r;
      q6_vld_r <= q5_vld_r;
      q7_vld_r <= q6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_s_r    <= s_i;
      q1_s2_r   <= DVS_W'(sq >> TQ);
      q1_side_r <= side_i;
      q1_dvs_r  <= dvs_i;

      q2_s_r    <= q1_s_r;
      q2_s2_r   <= q1_s2_r;
      q2_s3_r   <= DVS_W'(cu >> TQ);
      q2_side_r <= q1_side_r;
      q2_dvs_r  <= q1_dvs_r;

      q3_wpm_r  <= wmag(wp);
      q3_wpn_r  <= wp[W_W-1];
      q3_wam_r  <= wmag(wa);
      q3_wan_r  <= wa[W_W-1];
      q3_wbm_r  <= wmag(wb);
      q3_wbn_r  <= wb[W_W-1];
      q3_wv0m_r <= wmag(wv0);
      q3_wv0n_r <= wv0[W_W-1];
      q3_wv1m_r <= wmag(wv1);
      q3_wv1n_r <= wv1[W_W-1];
      q3_wdm_r  <= wmag(wd);
      q3_dpm_r  <= dpm_nxt;
      q3_dpn_r  <= dp[DW];
      q3_v0m_r  <= v0m_nxt;
      q3_v0n_r  <= q2_side_r.v0[DW-1];
      q3_v1m_r  <= v1m_nxt;
      q3_v1n_r  <= q2_side_r.v1[DW-1];
      q3_side_r <= q2_side_r;
      q3_dvs_r  <= q2_dvs_r;

      q4_pa_r   <= q3_dpm_r * q3_wpm_r;
      q4_pf_r   <= q3_dpm_r * q3_wdm_r;
      q4_pd_r   <= q3_v0m_r * q3_wv0m_r;
      q4_pe_r   <= q3_v1m_r * q3_wv1m_r;
      q4_mv0_r  <= q3_v0m_r * q3_dvs_r;
      q4_mv1_r  <= q3_v1m_r * q3_dvs_r;
      q4_wam_r  <= q3_wam_r;
      q4_wbm_r  <= q3_wbm_r;
      q4_aneg_r <= q3_dpn_r ^ q3_wpn_r;
      q4_fneg_r <= q3_dpn_r;
      q4_dneg_r <= q3_v0n_r ^ q3_wv0n_r;
      q4_eneg_r <= q3_v1n_r ^ q3_wv1n_r;
      q4_bneg_r <= q3_v0n_r ^ q3_wan_r;
      q4_cneg_r <= q3_v1n_r ^ q3_wbn_r;
      q4_side_r <= q3_side_r;
      q4_dvs_r  <= q3_dvs_r;

      q5_a_r    <= 34'(q4_pa_r >> TQ);
      q5_d_r    <= 33'(q4_pd_r >> TQ);
      q5_e_r    <= 33'(q4_pe_r >> TQ);
      q5_f_r    <= NUM_W'(q4_pf_r >> (TQ - FRAC_BITS));
      q5_blo_r  <= q4_mv0_r[31:0] * q4_wam_r;
      q5_bhi_r  <= q4_mv0_r[62:32] * q4_wam_r;
      q5_clo_r  <= q4_mv1_r[31:0] * q4_wbm_r;
      q5_chi_r  <= q4_mv1_r[62:32] * q4_wbm_r;
      q5_aneg_r <= q4_aneg_r;
      q5_bneg_r <= q4_bneg_r;
      q5_cneg_r <= q4_cneg_r;
      q5_dneg_r <= q4_dneg_r;
      q5_eneg_r <= q4_eneg_r;
      q5_fneg_r <= q4_fneg_r;
      q5_side_r <= q4_side_r;
      q5_dvs_r  <= q4_dvs_r;

      q6_as_r   <= as_nxt;
      q6_velp_r <= ds_nxt + es_nxt;
      q6_bm_r   <= POS_W'(bfull >> (TQ + FRAC_BITS));
      q6_cm_r   <= POS_W'(cfull >> (TQ + FRAC_BITS));
      q6_bneg_r <= q5_bneg_r;
      q6_cneg_r <= q5_cneg_r;
      q6_fneg_r <= q5_fneg_r;
      q6_f_r    <= q5_f_r;
      q6_side_r <= q5_side_r;
      q6_dvs_r  <= q5_dvs_r;

      q7_word_r <= q7_word_nxt;
    end
  end

  assign vld_o  = q7_vld_r;
  assign word_o = q7_word_r;

endmodule

[rtl/cubic_trajectory_point_top.sv]
// Top level of the cubic trajectory point block: entry stage, two divider chains and output queue.
`timescale 1ns / 1ps
// Path from the accepted input word to the result word: 1 entry stage, 30 cells of the time
// divider, 7 polynomial stages, 50 cells of the velocity divider, 1 output queue stage.
// Throughput: one word per cycle unless a full output queue holds the pipeline, set by the
// fully pipelined divider cells and multiplier stages. Reset (synchronous, active low)
// empties the pipeline and the two-entry output queue; no clearing pass is needed.
module cubic_trajectory_point_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_start_pos,
  input  logic signed [31:0] in_start_vel,
  input  logic signed [31:0] in_end_pos,
  input  logic signed [31:0] in_end_vel,
  input  logic signed [31:0] in_duration,
  input  logic signed [31:0] in_elapsed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_out,
  output logic signed [31:0] out_vel_out,
  output logic               out_status
);
  import ctp_pkg::*;

  typedef struct packed {
    logic [DW-1:0] pos;
    logic [DW-1:0] vel;
    logic          status;
  } res_t;

  localparam logic [DVS_W-1:0] S_ONE = DVS_W'(1) << TQ;

  // The whole pipeline advances together. It only holds when the output queue is
  // full and the consumer is not taking a word, so new input words keep flowing
  // while up to two finished results wait at the output.
  logic      en;
  logic [1:0] cnt_r;

  // Entry stage: classify the segment and load the first divider word.
  kind_t     kind_nxt;
  side_a_t   side_nxt;
  div_word_t entry_word_nxt;
  logic      entry_vld_r;
  div_word_t entry_word_r;

  always_comb begin
    priority if (in_duration <= 32'sd0) begin
      kind_nxt = KIND_BAD;
    end else if (in_elapsed < 32'sd0) begin
      kind_nxt = KIND_EARLY;
    end else if (in_elapsed > in_duration) begin
      kind_nxt = KIND_LATE;
    end else begin
      kind_nxt = KIND_OK;
    end
    side_nxt.kind = kind_nxt;
    side_nxt.eq   = (in_elapsed == in_duration);
    side_nxt.p0   = in_start_pos;
    side_nxt.v0   = in_start_vel;
    side_nxt.p1   = in_end_pos;
    side_nxt.v1   = in_end_vel;
    // The time divider needs a remainder below the divisor, so elapsed equal to
    // the duration is resolved after the chain as exactly one.
    entry_word_nxt.rem  = (kind_nxt == KIND_OK && !side_nxt.eq) ?
                          in_elapsed[DVS_W-1:0] : '0;
    entry_word_nxt.num  = '0;
    entry_word_nxt.dvs  = in_duration[DVS_W-1:0];
    entry_word_nxt.side = side_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= 1'b0;
    end else if (en) begin
      entry_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      entry_word_r <= entry_word_nxt;
    end
  end

  // Time divider: each cell produces one bit of s = elapsed * 2^30 / duration.
  logic      a_vld  [0:TQ];
  div_word_t a_word [0:TQ];

  assign a_vld[0]  = entry_vld_r;
  assign a_word[0] = entry_word_r;

  for (genvar i = 0; i < TQ; i++) begin : g_div_a
    ctp_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (a_vld[i]),
      .word_i (a_word[i]),
      .vld_o  (a_vld[i+1]),
      .word_o (a_word[i+1])
    );
  end

  side_a_t          a_side;
  logic [DVS_W-1:0] s_val;

  always_comb begin
    a_side = side_a_t'(a_word[TQ].side);
    s_val  = a_side.eq ? S_ONE : DVS_W'(a_word[TQ].num[TQ-1:0]);
  end

  // Polynomial pipeline: weights, products, position and the velocity term
  // that still has to be divided by the duration.
  logic      b_vld  [0:NUM_W];
  div_word_t b_word [0:NUM_W];

  ctp_poly u_poly (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (a_vld[TQ]),
    .s_i    (s_val),
    .side_i (a_side),
    .dvs_i  (a_word[TQ].dvs),
    .vld_o  (b_vld[0]),
    .word_o (b_word[0])
  );

  // Velocity divider: one quotient bit of the magnitude per cell.
  for (genvar j = 0; j < NUM_W; j++) begin : g_div_b
    ctp_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (b_vld[j]),
      .word_i (b_word[j]),
      .vld_o  (b_vld[j+1]),
      .word_o (b_word[j+1])
    );
  end

  // Final velocity sum and saturation. Out-of-range and bad segments give zero velocity.
  side_b_t                 b_side;
  logic signed [SAT_W-1:0] qs;
  logic signed [SAT_W-1:0] vsum;
  res_t                    res_nxt;

  always_comb begin
    b_side = side_b_t'(b_word[NUM_W].side[SIDEB_W-1:0]);
    qs     = $signed(SAT_W'(b_word[NUM_W].num));
    vsum   = SAT_W'(b_side.velp) + (b_side.fneg ? -qs : qs);
    res_nxt.pos    = b_side.pos;
    res_nxt.vel    = b_side.ok ? sat32(vsum) : '0;
    res_nxt.status = b_side.status;
  end

  // Two-entry output queue; slot 0 is the head.
  res_t slot0_r, slot1_r;
  logic push, pop;

  assign en   = (cnt_r != 2'd2) || out_ready;
  assign push = en && b_vld[NUM_W];
  assign pop  = (cnt_r != 2'd0) && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          slot0_r <= res_nxt;
        end else begin
          slot1_r <= res_nxt;
        end
      end
      2'b01: begin
        slot0_r <= slot1_r;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          slot0_r <= res_nxt;
        end else begin
          slot0_r <= slot1_r;
          slot1_r <= res_nxt;
        end
      end
      default: begin
        slot0_r <= slot0_r;
      end
    endcase
  end

  assign in_ready    = en;
  assign out_valid   = (cnt_r != 2'd0);
  assign out_pos_out = slot0_r.pos;
  assign out_vel_out = slot0_r.vel;
  assign out_status  = slot0_r.status;

endmodule
